### rtl/keyed_buffer_pool_with_aging_assert.svh
// Assertion macros for the keyed buffer pool.
// Used by the top level; needs a clock named clk and an active-low reset named rst_n.
`ifndef KEYED_BUFFER_POOL_WITH_AGING_ASSERT_SVH
`define KEYED_BUFFER_POOL_WITH_AGING_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KBPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KBPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/kbpa_pkg.sv
// Shared types and constants for the keyed buffer pool.
// No dependencies; used by the top level.
package kbpa_pkg;

    // Number of entries the pool can hold (1 to 31).
    localparam int POOL_ENTRIES = 16;
    localparam int IDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int CNT_W = $clog2(POOL_ENTRIES + 1);

    // Field widths of a transaction.
    localparam int DIM_W = 14;
    localparam int FMT_W = 4;
    localparam int LIFE_W = 16;
    localparam int ID_W = 16;
    localparam int CNT_OUT_W = 5;
    localparam int IN_DATA_W = 72;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [1:0] {
        OP_ACQUIRE = 2'd0,
        OP_RELEASE = 2'd1,
        OP_TICK    = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_REUSED   = 3'd0,
        ST_CREATED  = 3'd1,
        ST_FULL     = 3'd2,
        ST_RELEASED = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_TICKED   = 3'd5,
        ST_CLEARED  = 3'd6
    } status_t;

    // One pool entry as stored in the entry memory.
    typedef struct packed {
        logic [ID_W-1:0]   ident;
        logic [LIFE_W-1:0] life;
        logic              free;
        logic [FMT_W-1:0]  format;
        logic [DIM_W-1:0]  height;
        logic [DIM_W-1:0]  width;
    } entry_t;

endpackage

### rtl/kbpa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; the pool top level holds its entry list in it.
module kbpa_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered read data; data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/keyed_buffer_pool_with_aging.sv
// Keyed buffer pool with aging. A transaction on the slave side carries one command
// (acquire, release, tick or clear) and yields exactly one result transaction on the
// master side. The entry list lives in a one-read, one-write memory and is walked one
// entry per cycle. For each command:
// - An acquire or release walks the list from index 0 and stops at the first match.
// - One that matches nothing walks every entry in the pool.
// - A tick visits each entry it finds. Every entry present at the start
//   is visited once, whether it expires or not.
// - A clear does not walk the list.
// The single read port of the entry memory sets the walk rate. A finished result
// waits until the output register is empty or being emptied. A new command is taken
// once the previous result sits in the output register, even if it is not yet taken.
`include "keyed_buffer_pool_with_aging_assert.svh"

module keyed_buffer_pool_with_aging (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0: operation, buf_width, buf_height, buf_format, retention,
    // release_id, zero padding.
    input  logic [kbpa_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from bit 0: status, buffer_id, entry_count.
    output logic [kbpa_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam int IDX_W = kbpa_pkg::IDX_W;
    localparam int CNT_W = kbpa_pkg::CNT_W;
    localparam logic [CNT_W-1:0] POOL_MAX = CNT_W'(kbpa_pkg::POOL_ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIN
    } state_t;

    state_t                       state_reg, state_next;
    kbpa_pkg::op_t                op_reg, op_next;
    logic [kbpa_pkg::DIM_W-1:0]   width_reg, width_next;
    logic [kbpa_pkg::DIM_W-1:0]   height_reg, height_next;
    logic [kbpa_pkg::FMT_W-1:0]   format_reg, format_next;
    logic [kbpa_pkg::LIFE_W-1:0]  ret_reg, ret_next;
    logic [kbpa_pkg::ID_W-1:0]    rid_reg, rid_next;
    logic [CNT_W-1:0]             used_reg, used_next;
    logic [CNT_W-1:0]             cur_reg, cur_next;
    logic [kbpa_pkg::ID_W-1:0]    next_id_reg, next_id_next;
    kbpa_pkg::status_t            res_status_reg, res_status_next;
    logic [kbpa_pkg::ID_W-1:0]    res_id_reg, res_id_next;
    logic                         out_valid_reg, out_valid_next;
    logic [kbpa_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // Entry memory ports.
    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    kbpa_pkg::entry_t             ram_wdata;
    logic                         ram_re;
    logic [IDX_W-1:0]             ram_raddr;
    kbpa_pkg::entry_t             ram_q;

    // Helpers for the walk over the list.
    logic [CNT_W-1:0]             cur_inc;
    logic [CNT_W-1:0]             used_dec;
    logic                         walk_end;
    logic                         key_hit;
    logic                         id_hit;
    logic [kbpa_pkg::LIFE_W-1:0]  life_dec;
    logic                         out_free;

    kbpa_ram #(
        .DEPTH (kbpa_pkg::POOL_ENTRIES),
        .WIDTH ($bits(kbpa_pkg::entry_t)),
        .AW    (IDX_W)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    assign cur_inc  = cur_reg + 1'b1;
    assign used_dec = used_reg - 1'b1;
    assign walk_end = (cur_reg >= used_reg);
    assign key_hit  = ram_q.free && (ram_q.width == width_reg) &&
                      (ram_q.height == height_reg) && (ram_q.format == format_reg);
    assign id_hit   = (ram_q.ident == rid_reg);
    assign life_dec = ram_q.life - 1'b1;
    assign out_free = !out_valid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Command sequencer: decode, walk the entry list (except for a clear), then post the result.
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        format_next     = format_reg;
        ret_next        = ret_reg;
        rid_next        = rid_reg;
        used_next       = used_reg;
        cur_next        = cur_reg;
        next_id_next    = next_id_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = cur_reg[IDX_W-1:0];
        ram_wdata       = ram_q;
        ram_re          = 1'b0;
        ram_raddr       = cur_inc[IDX_W-1:0];

        // The result register empties when the master side takes it.
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next     = kbpa_pkg::op_t'(s_tdata[1:0]);
                    width_next  = s_tdata[15:2];
                    height_next = s_tdata[29:16];
                    format_next = s_tdata[33:30];
                    ret_next    = s_tdata[49:34];
                    rid_next    = s_tdata[65:50];
                    cur_next    = '0;
                    res_id_next = '0;
                    if (kbpa_pkg::op_t'(s_tdata[1:0]) == kbpa_pkg::OP_CLEAR)
                    begin
                        used_next       = '0;
                        res_status_next = kbpa_pkg::ST_CLEARED;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        // Fetch the first entry so it is ready in the first walk cycle.
                        ram_re     = (used_reg != '0);
                        ram_raddr  = '0;
                        state_next = S_RUN;
                    end
                end
            end

            S_RUN:
            begin
                unique case (op_reg)
                    kbpa_pkg::OP_ACQUIRE:
                    begin
                        if (walk_end)
                        begin
                            // No free entry with this key: append one, or report full.
                            if (used_reg < POOL_MAX)
                            begin
                                ram_we           = 1'b1;
                                ram_waddr        = used_reg[IDX_W-1:0];
                                ram_wdata.ident  = next_id_reg;
                                ram_wdata.life   = ret_reg;
                                ram_wdata.free   = 1'b0;
                                ram_wdata.format = format_reg;
                                ram_wdata.height = height_reg;
                                ram_wdata.width  = width_reg;
                                res_id_next      = next_id_reg;
                                next_id_next     = next_id_reg + 1'b1;
                                used_next        = used_reg + 1'b1;
                                res_status_next  = kbpa_pkg::ST_CREATED;
                            end
                            else
                            begin
                                res_status_next = kbpa_pkg::ST_FULL;
                            end
                            state_next = S_FIN;
                        end
                        else if (key_hit)
                        begin
                            ram_we          = 1'b1;
                            ram_wdata.free  = 1'b0;
                            res_id_next     = ram_q.ident;
                            res_status_next = kbpa_pkg::ST_REUSED;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            cur_next = cur_inc;
                            ram_re   = (cur_inc < used_reg);
                        end
                    end

                    kbpa_pkg::OP_RELEASE:
                    begin
                        if (walk_end)
                        begin
                            res_status_next = kbpa_pkg::ST_NOTFOUND;
                            state_next      = S_FIN;
                        end
                        else if (id_hit)
                        begin
                            ram_we          = 1'b1;
                            ram_wdata.free  = 1'b1;
                            res_status_next = kbpa_pkg::ST_RELEASED;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            cur_next = cur_inc;
                            ram_re   = (cur_inc < used_reg);
                        end
                    end

                    kbpa_pkg::OP_TICK:
                    begin
                        if (walk_end)
                        begin
                            res_status_next = kbpa_pkg::ST_TICKED;
                            state_next      = S_FIN;
                        end
                        else if (life_dec != '0)
                        begin
                            // Survivor: store the aged lifetime and move on.
                            ram_we         = 1'b1;
                            ram_wdata.life = life_dec;
                            cur_next       = cur_inc;
                            ram_re         = (cur_inc < used_reg);
                        end
                        else
                        begin
                            // Expired: the last entry takes this slot and is aged next.
                            used_next = used_dec;
                            ram_re    = (cur_reg < used_dec);
                            ram_raddr = used_dec[IDX_W-1:0];
                        end
                    end

                    kbpa_pkg::OP_CLEAR:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {kbpa_pkg::CNT_OUT_W'(used_reg), res_id_reg,
                                      res_status_reg};
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, list bookkeeping and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= kbpa_pkg::OP_ACQUIRE;
            width_reg      <= '0;
            height_reg     <= '0;
            format_reg     <= '0;
            ret_reg        <= '0;
            rid_reg        <= '0;
            used_reg       <= '0;
            cur_reg        <= '0;
            next_id_reg    <= '0;
            res_status_reg <= kbpa_pkg::ST_REUSED;
            res_id_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            format_reg     <= format_next;
            ret_reg        <= ret_next;
            rid_reg        <= rid_next;
            used_reg       <= used_next;
            cur_reg        <= cur_next;
            next_id_reg    <= next_id_next;
            res_status_reg <= res_status_next;
            res_id_reg     <= res_id_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
        end
    end

    // Checks on the list walk and memory use.
    `KBPA_ASSERT_NOW(a_used_bound, 1'b1, used_reg <= POOL_MAX, "entry count exceeds pool size")
    `KBPA_ASSERT_NOW(a_cursor_bound, state_reg == S_RUN, cur_reg <= used_reg, "cursor past end")
    `KBPA_ASSERT_NOW(a_write_in_walk, ram_we, state_reg == S_RUN, "entry write outside walk")
    `KBPA_ASSERT_NEXT(a_fin_posts, state_reg == S_FIN && out_free, out_valid_reg, "no result")

endmodule
